/* hdl/ctq_pkg.sv */
// Shared types, constants and helpers for the cylinder quad tessellator.
package ctq_pkg;

  localparam int unsigned MaxSlices        = 4096;
  localparam int unsigned MaxStacks        = 4096;
  localparam int unsigned CountW           = 13;
  localparam int unsigned DivW             = 45;
  localparam int unsigned DivStepsPerStage = 2;
  localparam int unsigned DivStages        = (DivW + DivStepsPerStage - 1) / DivStepsPerStage;
  localparam int unsigned CordicSteps      = 30;

  localparam logic signed [33:0] CordicGainInv = 34'sd652032874;

  localparam logic [29:0] AtanTurns [CordicSteps] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722,
    30'd20861, 30'd10430, 30'd5215, 30'd2608, 30'd1304,
    30'd652, 30'd326, 30'd163, 30'd81, 30'd41,
    30'd20, 30'd10, 30'd5, 30'd3, 30'd1
  };

  typedef enum logic [2:0] {
    CFG_CENTER_X    = 3'd0,
    CFG_CENTER_Y    = 3'd1,
    CFG_CENTER_Z    = 3'd2,
    CFG_BASE_RADIUS = 3'd3,
    CFG_TOP_RADIUS  = 3'd4,
    CFG_HEIGHT      = 3'd5,
    CFG_SLICE_COUNT = 3'd6,
    CFG_STACK_COUNT = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [11:0] slice_index;
    logic [11:0] stack_index;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic [1:0]         corner;
    logic               last_corner;
    logic               bad_index;
  } out_word_t;

  typedef struct packed {
    logic [CountW-1:0] rem;
    logic [DivW-1:0]   work;
  } div_state_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] corner;
    logic       bad;
    logic       neg_r;
    logic       neg_z;
  } meta_t;

  // one restoring division step: remainder stays below the divisor
  function automatic div_state_t div_step(div_state_t s, logic [CountW-1:0] d);
    logic [CountW:0] trial;
    div_state_t      r;
    trial  = {s.rem, s.work[DivW-1]};
    r.work = {s.work[DivW-2:0], 1'b0};
    if (trial >= {1'b0, d}) begin
      r.rem     = CountW'(trial - {1'b0, d});
      r.work[0] = 1'b1;
    end else begin
      r.rem = trial[CountW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -36'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Q4.30 to Q1.15, round half up, saturate
  function automatic logic signed [15:0] to_q15(logic signed [33:0] v);
    logic signed [34:0] t;
    logic signed [15:0] r;
    t = (35'(v) + 35'sd16384) >>> 15;
    if (t > 35'sd32767) begin
      r = 16'sh7fff;
    end else if (t < -35'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = t[15:0];
    end
    return r;
  endfunction

endpackage

/* hdl/ctq_div.sv */
// Pipelined restoring divider, 45-bit dividend by 13-bit divisor, two bits per stage.
module ctq_div (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [ctq_pkg::DivW-1:0]    dividend_i,
  input  logic [ctq_pkg::CountW-1:0]  divisor_i,
  output logic [ctq_pkg::DivW-1:0]    quotient_o
);

  ctq_pkg::div_state_t state_q [ctq_pkg::DivStages];
  ctq_pkg::div_state_t stage_in [ctq_pkg::DivStages];

  for (genvar s = 0; s < ctq_pkg::DivStages; s++) begin : g_stage
    ctq_pkg::div_state_t st_d;

    if (s == 0) begin : g_first
      assign stage_in[s] = '{rem: '0, work: dividend_i};
    end else begin : g_rest
      assign stage_in[s] = state_q[s-1];
    end

    always_comb begin
      st_d = stage_in[s];
      for (int k = 0; k < ctq_pkg::DivStepsPerStage; k++) begin
        if (s * ctq_pkg::DivStepsPerStage + k < ctq_pkg::DivW) begin
          st_d = ctq_pkg::div_step(st_d, divisor_i);
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        state_q[s] <= st_d;
      end
    end
  end

  assign quotient_o = state_q[ctq_pkg::DivStages-1].work;

endmodule

/* hdl/cylinder_quad_tessellator_core.sv */
// Cylinder quad tessellator: one truncated-cone quad request in, four vertex words out.
//
// Each accepted request yields four vertex words, corners (i,j), (i+1,j), (i+1,j+1), (i,j+1),
// one per cycle while the output is not stalled; a new request is taken as the last corner of
// the previous one enters the pipeline, and the single vertex output port sets that limit. The
// vertex pipeline has one expander stage, a dividend stage, 23 stages of a two-bit-per-stage
// divider, one fixup stage, 30 CORDIC stages, two multiply and round stages and the output
// register. Output stall freezes the whole pipeline; nothing is dropped or repeated. The user
// must write configuration only while no request is in flight; the block does not enforce it.
module cylinder_quad_tessellator_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ctq_pkg::in_word_t    in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ctq_pkg::out_word_t   out_word_o,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  localparam int unsigned DS = ctq_pkg::DivStages;
  localparam int unsigned CS = ctq_pkg::CordicSteps;

  typedef struct packed {
    ctq_pkg::meta_t     meta;
    logic [1:0]         quad;
    logic signed [31:0] r;
    logic signed [32:0] dz;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
  } cside_t;

  typedef struct packed {
    ctq_pkg::meta_t meta;
    logic [16:0]    tex_u;
    logic [16:0]    tex_v;
  } mside_t;

  // configuration
  logic signed [31:0]              cen_x_q, cen_y_q, cen_z_q, height_q;
  logic [30:0]                     base_q, top_q;
  logic [ctq_pkg::CountW-1:0]      slices_q, stacks_q, ns, nt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cen_x_q  <= '0;
      cen_y_q  <= '0;
      cen_z_q  <= '0;
      base_q   <= 31'd65536;
      top_q    <= 31'd65536;
      height_q <= 32'sd65536;
      slices_q <= 13'd16;
      stacks_q <= 13'd1;
    end else if (cfg_we_i) begin
      unique case (ctq_pkg::cfg_idx_e'(cfg_index_i))
        ctq_pkg::CFG_CENTER_X:    cen_x_q  <= cfg_data_i;
        ctq_pkg::CFG_CENTER_Y:    cen_y_q  <= cfg_data_i;
        ctq_pkg::CFG_CENTER_Z:    cen_z_q  <= cfg_data_i;
        ctq_pkg::CFG_BASE_RADIUS: base_q   <= cfg_data_i[30:0];
        ctq_pkg::CFG_TOP_RADIUS:  top_q    <= cfg_data_i[30:0];
        ctq_pkg::CFG_HEIGHT:      height_q <= cfg_data_i;
        ctq_pkg::CFG_SLICE_COUNT: slices_q <= cfg_data_i[12:0];
        ctq_pkg::CFG_STACK_COUNT: stacks_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  assign ns = (slices_q > 13'(ctq_pkg::MaxSlices)) ? 13'(ctq_pkg::MaxSlices) : slices_q;
  assign nt = (stacks_q > 13'(ctq_pkg::MaxStacks)) ? 13'(ctq_pkg::MaxStacks) : stacks_q;

  // pipeline advance
  logic               adv;
  logic               out_valid_q;
  ctq_pkg::out_word_t out_q;

  assign adv = !out_valid_q || !out_stall_i;

  // request expander
  ctq_pkg::in_word_t item_q;
  logic              busy_q;
  logic [1:0]        corner_q;
  logic              in_acc;

  assign in_stall_o = busy_q && !(adv && corner_q == 2'd3);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      corner_q <= '0;
    end else if (in_acc) begin
      busy_q   <= 1'b1;
      corner_q <= '0;
    end else if (adv && busy_q) begin
      corner_q <= corner_q + 2'd1;
      if (corner_q == 2'd3) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_word_i;
    end
  end

  // vertex indices and dividends
  logic [12:0]        ii, jj;
  logic               bad;
  logic signed [31:0] rdiff;
  logic signed [45:0] prod_r, prod_z;
  logic [45:0]        mag_r, mag_z;

  assign ii    = {1'b0, item_q.slice_index} +
                 13'(corner_q == 2'd1 || corner_q == 2'd2);
  assign jj    = {1'b0, item_q.stack_index} + 13'(corner_q[1]);
  assign bad   = ({1'b0, item_q.slice_index} >= ns) || ({1'b0, item_q.stack_index} >= nt);
  assign rdiff = $signed({1'b0, top_q}) - $signed({1'b0, base_q});
  assign prod_r = 46'(rdiff) * 46'($signed({1'b0, jj}));
  assign prod_z = 46'(height_q) * 46'($signed({1'b0, jj}));
  assign mag_r  = prod_r[45] ? 46'(-prod_r) : 46'(prod_r);
  assign mag_z  = prod_z[45] ? 46'(-prod_z) : 46'(prod_z);

  ctq_pkg::meta_t            s1_meta_q;
  logic [ctq_pkg::DivW-1:0]  dv_ph_q, dv_tv_q, dv_r_q, dv_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_meta_q <= '0;
    end else if (adv) begin
      s1_meta_q <= '{valid: busy_q, corner: corner_q, bad: bad,
                     neg_r: prod_r[45], neg_z: prod_z[45]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_ph_q <= {ii, 32'b0};
      dv_tv_q <= {16'b0, jj, 16'b0};
      dv_r_q  <= mag_r[44:0];
      dv_z_q  <= mag_z[44:0];
    end
  end

  // dividers
  logic [ctq_pkg::DivW-1:0] q_ph, q_tv, q_r, q_z;

  ctq_div u_div_ph (.clk_i, .en_i(adv), .dividend_i(dv_ph_q), .divisor_i(ns), .quotient_o(q_ph));
  ctq_div u_div_tv (.clk_i, .en_i(adv), .dividend_i(dv_tv_q), .divisor_i(nt), .quotient_o(q_tv));
  ctq_div u_div_r  (.clk_i, .en_i(adv), .dividend_i(dv_r_q),  .divisor_i(nt), .quotient_o(q_r));
  ctq_div u_div_z  (.clk_i, .en_i(adv), .dividend_i(dv_z_q),  .divisor_i(nt), .quotient_o(q_z));

  ctq_pkg::meta_t meta_q [DS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DS; k++) meta_q[k] <= '0;
    end else if (adv) begin
      meta_q[0] <= s1_meta_q;
      for (int k = 1; k < DS; k++) meta_q[k] <= meta_q[k-1];
    end
  end

  // sign fixup, radius and z offset
  ctq_pkg::meta_t     dm;
  logic signed [46:0] qr_s, qz_s, r_sum;
  cside_t             e_side_q;
  logic [29:0]        e_phase_q;

  assign dm    = meta_q[DS-1];
  assign qr_s  = dm.neg_r ? -$signed({2'b0, q_r}) : $signed({2'b0, q_r});
  assign qz_s  = dm.neg_z ? -$signed({2'b0, q_z}) : $signed({2'b0, q_z});
  assign r_sum = qr_s + 47'($signed({1'b0, base_q}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_side_q <= '0;
    end else if (adv) begin
      e_side_q <= '{meta: dm, quad: q_ph[31:30], r: r_sum[31:0], dz: qz_s[32:0],
                    tex_u: q_ph[32:16], tex_v: q_tv[16:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_phase_q <= q_ph[29:0];
    end
  end

  // CORDIC
  logic signed [33:0] cx_q [CS];
  logic signed [33:0] cy_q [CS];
  logic signed [32:0] cz_q [CS];
  cside_t             cside_q [CS];

  for (genvar k = 0; k < CS; k++) begin : g_cordic
    logic signed [33:0] x_in, y_in;
    logic signed [32:0] z_in, at;
    cside_t             sd_in;

    if (k == 0) begin : g_first
      assign x_in  = ctq_pkg::CordicGainInv;
      assign y_in  = '0;
      assign z_in  = $signed({3'b0, e_phase_q});
      assign sd_in = e_side_q;
    end else begin : g_rest
      assign x_in  = cx_q[k-1];
      assign y_in  = cy_q[k-1];
      assign z_in  = cz_q[k-1];
      assign sd_in = cside_q[k-1];
    end

    assign at = $signed({3'b0, ctq_pkg::AtanTurns[k]});

    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (!z_in[32]) begin
          cx_q[k] <= x_in - (y_in >>> k);
          cy_q[k] <= y_in + (x_in >>> k);
          cz_q[k] <= z_in - at;
        end else begin
          cx_q[k] <= x_in + (y_in >>> k);
          cy_q[k] <= y_in - (x_in >>> k);
          cz_q[k] <= z_in + at;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cside_q[k] <= '0;
      end else if (adv) begin
        cside_q[k] <= sd_in;
      end
    end
  end

  // quadrant rotation, products, normals
  cside_t             cf;
  logic signed [33:0] cos_v, sin_v;

  assign cf = cside_q[CS-1];

  always_comb begin
    case (cf.quad)
      2'd0: begin cos_v = cx_q[CS-1];  sin_v = cy_q[CS-1];  end
      2'd1: begin cos_v = -cy_q[CS-1]; sin_v = cx_q[CS-1];  end
      2'd2: begin cos_v = -cx_q[CS-1]; sin_v = -cy_q[CS-1]; end
      default: begin cos_v = cy_q[CS-1]; sin_v = -cx_q[CS-1]; end
    endcase
  end

  mside_t             m1_side_q, m2_side_q;
  logic signed [65:0] px_q, py_q;
  logic signed [15:0] m1_nx_q, m1_ny_q, m2_nx_q, m2_ny_q;
  logic signed [31:0] m1_pz_q, m2_pz_q;
  logic signed [35:0] tx_q, ty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_side_q <= '0;
      m2_side_q <= '0;
    end else if (adv) begin
      m1_side_q <= '{meta: cf.meta, tex_u: cf.tex_u, tex_v: cf.tex_v};
      m2_side_q <= m1_side_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      px_q    <= 66'(cf.r) * 66'(cos_v);
      py_q    <= 66'(cf.r) * 66'(sin_v);
      m1_nx_q <= ctq_pkg::to_q15(cos_v);
      m1_ny_q <= ctq_pkg::to_q15(sin_v);
      m1_pz_q <= ctq_pkg::sat32(36'(cen_z_q) + 36'(cf.dz));
      tx_q    <= 36'((px_q + 66'sd536870912) >>> 30);
      ty_q    <= 36'((py_q + 66'sd536870912) >>> 30);
      m2_nx_q <= m1_nx_q;
      m2_ny_q <= m1_ny_q;
      m2_pz_q <= m1_pz_q;
    end
  end

  // output register
  logic ok;

  assign ok = !m2_side_q.meta.bad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= m2_side_q.meta.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.pos_x       <= ok ? ctq_pkg::sat32(36'(cen_x_q) + tx_q) : '0;
      out_q.pos_y       <= ok ? ctq_pkg::sat32(36'(cen_y_q) + ty_q) : '0;
      out_q.pos_z       <= ok ? m2_pz_q : '0;
      out_q.normal_x    <= ok ? m2_nx_q : '0;
      out_q.normal_y    <= ok ? m2_ny_q : '0;
      out_q.tex_u       <= ok ? m2_side_q.tex_u : '0;
      out_q.tex_v       <= ok ? m2_side_q.tex_v : '0;
      out_q.corner      <= m2_side_q.meta.corner;
      out_q.last_corner <= (m2_side_q.meta.corner == 2'd3);
      out_q.bad_index   <= m2_side_q.meta.bad;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

/* bench/tb_top.sv */
// Testbench for the cylinder quad tessellator core: random and directed quads checked per vertex.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 100;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i, cfg_we_i;
  ctq_pkg::in_word_t in_word_i;
  ctq_pkg::out_word_t out_word_o;
  ctq_pkg::cfg_idx_e cfg_index_i;
  logic [31:0] cfg_data_i;

  cylinder_quad_tessellator_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_word_i, .out_valid_o,
    .out_stall_i, .out_word_o, .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  // shadow copy of the cone setup
  longint cx, cy, cz, rad_base, rad_top, cone_h;
  int unsigned n_slices, n_stacks;

  ctq_pkg::in_word_t quad_q[$];
  ctq_pkg::out_word_t vertex_q[$];
  int unsigned idle_mode;
  int unsigned errors, vertices_seen, quads_sent;
  int unsigned cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round_q15(longint v);
    longint t;
    t = (v + 16384) >>> 15;
    if (t > 32767) return 32767;
    if (t < -32768) return -32768;
    return t;
  endfunction

  function automatic ctq_pkg::out_word_t vertex_of(logic [11:0] si, logic [11:0] ti, int k);
    ctq_pkg::out_word_t w;
    longint unsigned ns, nt, ii, jj;
    logic [31:0] phase;
    longint x, y, z, t, c, s, r, dz;
    logic bad;
    ns = (n_slices > ctq_pkg::MaxSlices) ? ctq_pkg::MaxSlices : n_slices;
    nt = (n_stacks > ctq_pkg::MaxStacks) ? ctq_pkg::MaxStacks : n_stacks;
    bad = (si >= ns) || (ti >= nt);
    w = '0;
    ii = si + ((k == 1 || k == 2) ? 1 : 0);
    jj = ti + ((k >= 2) ? 1 : 0);
    if (!bad) begin
      phase = 32'((ii << 32) / ns);
      x = 652032874;
      y = 0;
      z = longint'(phase[29:0]);
      for (int n = 0; n < ctq_pkg::CordicSteps; n++) begin
        if (z >= 0) begin
          t = x - (y >>> n); y = y + (x >>> n); x = t; z -= longint'(ctq_pkg::AtanTurns[n]);
        end else begin
          t = x + (y >>> n); y = y - (x >>> n); x = t; z += longint'(ctq_pkg::AtanTurns[n]);
        end
      end
      case (phase[31:30])
        2'd0: begin c = x; s = y; end
        2'd1: begin c = -y; s = x; end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
      r = rad_base + ((rad_top - rad_base) * longint'(jj)) / longint'(nt);
      dz = (cone_h * longint'(jj)) / longint'(nt);
      w.pos_x = 32'(clamp32(cx + ((r * c + (64'sd1 << 29)) >>> 30)));
      w.pos_y = 32'(clamp32(cy + ((r * s + (64'sd1 << 29)) >>> 30)));
      w.pos_z = 32'(clamp32(cz + dz));
      w.normal_x = 16'(round_q15(c));
      w.normal_y = 16'(round_q15(s));
      w.tex_u = 17'((ii << 16) / ns);
      w.tex_v = 17'((jj << 16) / nt);
    end
    w.corner = 2'(k);
    w.last_corner = (k == 3);
    w.bad_index = bad;
    return w;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_word_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        for (int k = 0; k < 4; k++) vertex_q.push_back(vertex_of(in_word_i.slice_index,
                                                                 in_word_i.stack_index, k));
        quads_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (quad_q.size() != 0 &&
            $urandom_range(99, 0) >= (idle_mode == 0 ? 32 : idle_mode == 1 ? 75 : 0)) begin
          in_valid_i <= 1'b1;
          in_word_i <= quad_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, longint e, longint a);
    if (e != a) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      errors++;
    end
  endtask

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (vertex_q.size() == 0) begin
          $error("vertex word with nothing expected");
          errors++;
        end else begin
          ctq_pkg::out_word_t e;
          e = vertex_q.pop_front();
          vertices_seen++;
          check_field("pos_x", e.pos_x, out_word_o.pos_x);
          check_field("pos_y", e.pos_y, out_word_o.pos_y);
          check_field("pos_z", e.pos_z, out_word_o.pos_z);
          check_field("normal_x", e.normal_x, out_word_o.normal_x);
          check_field("normal_y", e.normal_y, out_word_o.normal_y);
          check_field("tex_u", e.tex_u, out_word_o.tex_u);
          check_field("tex_v", e.tex_v, out_word_o.tex_v);
          check_field("corner", e.corner, out_word_o.corner);
          check_field("last_corner", e.last_corner, out_word_o.last_corner);
          check_field("bad_index", e.bad_index, out_word_o.bad_index);
        end
      end
      out_stall_i <= $urandom_range(99, 0) < (idle_mode == 0 ? 75 : idle_mode == 1 ? 32 : 0);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic cfg_write(ctq_pkg::cfg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    case (idx)
      ctq_pkg::CFG_CENTER_X: cx = longint'(signed'(val));
      ctq_pkg::CFG_CENTER_Y: cy = longint'(signed'(val));
      ctq_pkg::CFG_CENTER_Z: cz = longint'(signed'(val));
      ctq_pkg::CFG_BASE_RADIUS: rad_base = longint'(val[30:0]);
      ctq_pkg::CFG_TOP_RADIUS: rad_top = longint'(val[30:0]);
      ctq_pkg::CFG_HEIGHT: cone_h = longint'(signed'(val));
      ctq_pkg::CFG_SLICE_COUNT: n_slices = val[12:0];
      default: n_stacks = val[12:0];
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (quad_q.size() != 0 || in_valid_i || vertex_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic add_quad(int unsigned si, int unsigned ti);
    ctq_pkg::in_word_t w;
    w.slice_index = 12'(si);
    w.stack_index = 12'(ti);
    quad_q.push_back(w);
  endtask

  task automatic setup(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] rb,
                       logic [31:0] rt, logic [31:0] h, logic [31:0] ns, logic [31:0] nt);
    cfg_write(ctq_pkg::CFG_CENTER_X, x);
    cfg_write(ctq_pkg::CFG_CENTER_Y, y);
    cfg_write(ctq_pkg::CFG_CENTER_Z, z);
    cfg_write(ctq_pkg::CFG_BASE_RADIUS, rb);
    cfg_write(ctq_pkg::CFG_TOP_RADIUS, rt);
    cfg_write(ctq_pkg::CFG_HEIGHT, h);
    cfg_write(ctq_pkg::CFG_SLICE_COUNT, ns);
    cfg_write(ctq_pkg::CFG_STACK_COUNT, nt);
  endtask

  initial begin
    int unsigned ns, nt;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_word_i = '0;
    out_stall_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = ctq_pkg::CFG_CENTER_X;
    cfg_data_i = '0;
    cx = 0; cy = 0; cz = 0; rad_base = 65536; rad_top = 65536; cone_h = 65536;
    n_slices = 16; n_stacks = 1;
    idle_mode = 0;
    errors = 0; vertices_seen = 0; quads_sent = 0; cycles = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset setup: wrap of the last slice, out of range on either index
    add_quad(0, 0); add_quad(15, 0); add_quad(7, 0); add_quad(16, 0);
    add_quad(0, 1); add_quad(4095, 4095);
    drain();
    // saturating extremes, counts above the limit
    setup(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h0,
          32'h80000000, 32'h1fff, 32'h1fff);
    add_quad(0, 0); add_quad(4095, 4095); add_quad(2048, 1000); add_quad(1024, 4095);
    drain();
    setup(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h0, 32'h7fffffff,
          32'h7fffffff, 32'd1, 32'd4096);
    add_quad(0, 0); add_quad(0, 4095); add_quad(1, 0); add_quad(0, 2000);
    drain();
    // zero counts make everything out of range
    setup(32'h0, 32'h0, 32'h0, 32'h10000, 32'h20000, 32'h10000, 32'd0, 32'd0);
    add_quad(0, 0); add_quad(5, 5);
    drain();
    setup(32'h0, 32'h0, 32'h0, 32'h10000, 32'h20000, 32'h10000, 32'd3, 32'd2);
    add_quad(0, 0); add_quad(1, 1); add_quad(2, 1); add_quad(3, 0); add_quad(2, 2);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      idle_mode = ph / 2;
      ns = ($urandom_range(3, 0) == 0) ? $urandom_range(8191, 0) : $urandom_range(64, 1);
      nt = ($urandom_range(3, 0) == 0) ? $urandom_range(8191, 0) : $urandom_range(16, 1);
      setup($urandom, $urandom, $urandom, $urandom_range(32'h7fffffff, 0) >> $urandom_range(12, 0),
            $urandom_range(32'h7fffffff, 0) >> $urandom_range(12, 0), $urandom,
            ns, nt);
      ns = (ns > ctq_pkg::MaxSlices) ? ctq_pkg::MaxSlices : ns;
      nt = (nt > ctq_pkg::MaxStacks) ? ctq_pkg::MaxStacks : nt;
      for (int n = 0; n < 17; n++) begin
        if ($urandom_range(9, 0) < 8 && ns != 0 && nt != 0)
          add_quad($urandom_range(ns - 1, 0), $urandom_range(nt - 1, 0));
        else
          add_quad($urandom_range(4095, 0), $urandom_range(4095, 0));
      end
      drain();
    end

    $display("Ran %0d quads (%0d vertices) over directed extremes and six random cone setups,",
             quads_sent, vertices_seen);
    $display("with sender and receiver stalls in both mixes and without stalls.");
    if (errors == 0 && vertex_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
